>>> rtl/tfn_pkg.sv
// Package for the triangle face normal pipeline.
// Holds the transaction types, the word widths of every stage and the tag
// that rides along each triangle. Depends on nothing.
package tfn_pkg;

	localparam int COORD_BITS = 16;
	localparam int OUT_BITS   = 16;
	localparam int UNIT_Q     = 16384;

	// edge vectors, products, cross product and its magnitude
	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int MAG_W   = CROSS_W - 1;
	localparam int SHIFT_W = $clog2(MAG_W + 1);

	// normalized magnitudes, squares and their sum
	localparam int FIT_BITS = 30;
	localparam int SQ_W     = 2 * FIT_BITS;
	localparam int SUM_W    = SQ_W + 2;

	// divider: quotient of m^2 * 2^30 by the sum of squares
	localparam int QUO_W = FIT_BITS + 1;
	localparam int REM_W = SUM_W + 1;

	// integer square root of the quotient
	localparam int ROOT_W = 16;
	localparam int RRM_W  = ROOT_W + 3;
	localparam int RAD_W  = 2 * ROOT_W;

	localparam int LINE_DEPTH = QUO_W + ROOT_W;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] ax;
		logic signed [COORD_BITS-1:0] ay;
		logic signed [COORD_BITS-1:0] az;
		logic signed [COORD_BITS-1:0] bx;
		logic signed [COORD_BITS-1:0] by_coord;
		logic signed [COORD_BITS-1:0] bz;
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic signed [COORD_BITS-1:0] cz;
	} face_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] nx;
		logic signed [OUT_BITS-1:0] ny;
		logic signed [OUT_BITS-1:0] nz;
		logic                       degenerate;
	} normal_t;

	// per-triangle side information carried past the divider and root
	typedef struct packed {
		logic [2:0] neg;
		logic       degen;
	} tag_t;

endpackage

>>> rtl/tfn_cross.sv
// Front end: edge vectors, the six products and the exact cross product in
// sign-magnitude form, four register stages. Uses tfn_pkg.
module tfn_cross import tfn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_v,
	input  face_t              face,
	output logic               out_v,
	output logic [2:0]         neg,
	output logic [MAG_W-1:0]   mag [3]
);

	logic                      v_s1, v_s2, v_s3, v_s4;
	logic signed [DIFF_W-1:0]  ux_s1, uy_s1, uz_s1, vx_s1, vy_s1, vz_s1;
	logic signed [PROD_W-1:0]  p_s2 [6];
	logic signed [CROSS_W-1:0] x_s3 [3];
	logic [2:0]                neg_s4;
	logic [MAG_W-1:0]          mag_s4 [3];
	logic [CROSS_W-1:0]        abs_x [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			abs_x[i] = x_s3[i][CROSS_W-1] ? (~x_s3[i] + 1'b1) : x_s3[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// U = C - A, V = B - A
			ux_s1 <= {face.cx[COORD_BITS-1], face.cx} - {face.ax[COORD_BITS-1], face.ax};
			uy_s1 <= {face.cy[COORD_BITS-1], face.cy} - {face.ay[COORD_BITS-1], face.ay};
			uz_s1 <= {face.cz[COORD_BITS-1], face.cz} - {face.az[COORD_BITS-1], face.az};
			vx_s1 <= {face.bx[COORD_BITS-1], face.bx} - {face.ax[COORD_BITS-1], face.ax};
			vy_s1 <= {face.by_coord[COORD_BITS-1], face.by_coord}
				- {face.ay[COORD_BITS-1], face.ay};
			vz_s1 <= {face.bz[COORD_BITS-1], face.bz} - {face.az[COORD_BITS-1], face.az};

			p_s2[0] <= uy_s1 * vz_s1;
			p_s2[1] <= uz_s1 * vy_s1;
			p_s2[2] <= uz_s1 * vx_s1;
			p_s2[3] <= ux_s1 * vz_s1;
			p_s2[4] <= ux_s1 * vy_s1;
			p_s2[5] <= uy_s1 * vx_s1;

			for (int i = 0; i < 3; i++) begin
				x_s3[i] <= {p_s2[2*i][PROD_W-1], p_s2[2*i]}
					- {p_s2[2*i+1][PROD_W-1], p_s2[2*i+1]};
			end

			for (int i = 0; i < 3; i++) begin
				neg_s4[i] <= x_s3[i][CROSS_W-1];
				mag_s4[i] <= abs_x[i][MAG_W-1:0];
			end
		end
	end

	assign out_v = v_s4;
	assign neg   = neg_s4;
	assign mag   = mag_s4;

endmodule

>>> rtl/tfn_norm.sv
// Block-normalizes the three cross product magnitudes below 2^30, then forms
// their squares and the sum of squares, four register stages. Uses tfn_pkg.
module tfn_norm import tfn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_v,
	input  logic [2:0]         neg,
	input  logic [MAG_W-1:0]   mag [3],
	output logic               out_v,
	output tag_t               tag,
	output logic [SQ_W-1:0]    sq [3],
	output logic [SUM_W-1:0]   sum
);

	logic                 v_s5, v_s6, v_s7, v_s8;
	tag_t                 tag_s5, tag_s6, tag_s7, tag_s8;
	logic [MAG_W-1:0]     mag_s5 [3];
	logic [SHIFT_W-1:0]   sh_s5;
	logic [FIT_BITS-1:0]  m_s6 [3];
	logic [SQ_W-1:0]      sq_s7 [3];
	logic [SQ_W-1:0]      sq_s8 [3];
	logic [SUM_W-1:0]     sum_s8;
	logic [MAG_W-1:0]     any_bits;
	logic [SHIFT_W-1:0]   len;
	logic [SHIFT_W-1:0]   sh;
	logic [MAG_W-1:0]     shifted [3];

	always_comb begin
		any_bits = mag[0] | mag[1] | mag[2];
		len = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (any_bits[i]) begin
				len = SHIFT_W'(i + 1);
			end
		end
		sh = (len > SHIFT_W'(FIT_BITS)) ? (len - SHIFT_W'(FIT_BITS)) : '0;
		for (int i = 0; i < 3; i++) begin
			shifted[i] = mag_s5[i] >> sh_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s5 <= in_v;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s5.neg   <= neg;
			tag_s5.degen <= (any_bits == '0);
			mag_s5       <= mag;
			sh_s5        <= sh;

			tag_s6 <= tag_s5;
			for (int i = 0; i < 3; i++) begin
				m_s6[i] <= shifted[i][FIT_BITS-1:0];
			end

			tag_s7 <= tag_s6;
			for (int i = 0; i < 3; i++) begin
				sq_s7[i] <= m_s6[i] * m_s6[i];
			end

			tag_s8 <= tag_s7;
			sq_s8  <= sq_s7;
			sum_s8 <= SUM_W'(sq_s7[0]) + SUM_W'(sq_s7[1]) + SUM_W'(sq_s7[2]);
		end
	end

	assign out_v = v_s8;
	assign tag   = tag_s8;
	assign sq    = sq_s8;
	assign sum   = sum_s8;

endmodule

>>> rtl/tfn_div.sv
// Restoring divider, one quotient bit per register stage: floor(sq * 2^30 / sum)
// with sq no larger than sum. Uses tfn_pkg.
module tfn_div import tfn_pkg::*; (
	input  logic             clk,
	input  logic             adv,
	input  logic [SQ_W-1:0]  sq,
	input  logic [SUM_W-1:0] sum,
	output logic [QUO_W-1:0] quo
);

	logic [REM_W-1:0] rem_s [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W];
	logic [SUM_W-1:0] dvs_s [QUO_W];
	logic [REM_W-1:0] trial [QUO_W];
	logic             ge    [QUO_W];
	logic [REM_W-1:0] nxt   [QUO_W];

	always_comb begin
		trial[0] = REM_W'(sq);
		ge[0]    = trial[0] >= REM_W'(sum);
		nxt[0]   = ge[0] ? (trial[0] - REM_W'(sum)) : trial[0];
		for (int k = 1; k < QUO_W; k++) begin
			trial[k] = {rem_s[k-1][REM_W-2:0], 1'b0};
			ge[k]    = trial[k] >= REM_W'(dvs_s[k-1]);
			nxt[k]   = ge[k] ? (trial[k] - REM_W'(dvs_s[k-1])) : trial[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= nxt[0];
			quo_s[0] <= QUO_W'(ge[0]);
			dvs_s[0] <= sum;
			for (int k = 1; k < QUO_W; k++) begin
				rem_s[k] <= nxt[k];
				quo_s[k] <= {quo_s[k-1][QUO_W-2:0], ge[k]};
				dvs_s[k] <= dvs_s[k-1];
			end
		end
	end

	assign quo = quo_s[QUO_W-1];

endmodule

>>> rtl/tfn_isqrt.sv
// Digit-by-digit integer square root, one root bit per register stage.
// Uses tfn_pkg.
module tfn_isqrt import tfn_pkg::*; (
	input  logic              clk,
	input  logic              adv,
	input  logic [QUO_W-1:0]  rad,
	output logic [ROOT_W-1:0] root
);

	logic [RRM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [RAD_W-1:0]  rad_s  [ROOT_W];
	logic [RRM_W-1:0]  rem_in  [ROOT_W];
	logic [ROOT_W-1:0] root_in [ROOT_W];
	logic [RAD_W-1:0]  rad_in  [ROOT_W];
	logic [RRM_W-1:0]  cur     [ROOT_W];
	logic [RRM_W-1:0]  trial   [ROOT_W];
	logic              ge      [ROOT_W];

	always_comb begin
		rem_in[0]  = '0;
		root_in[0] = '0;
		rad_in[0]  = RAD_W'(rad);
		for (int k = 1; k < ROOT_W; k++) begin
			rem_in[k]  = rem_s[k-1];
			root_in[k] = root_s[k-1];
			rad_in[k]  = rad_s[k-1];
		end
		for (int k = 0; k < ROOT_W; k++) begin
			// bring down the next pair of radicand bits
			cur[k]   = {rem_in[k][RRM_W-3:0], rad_in[k][2*(ROOT_W-1-k)+1 -: 2]};
			trial[k] = RRM_W'({root_in[k], 2'b01});
			ge[k]    = cur[k] >= trial[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < ROOT_W; k++) begin
				rem_s[k]  <= ge[k] ? (cur[k] - trial[k]) : cur[k];
				root_s[k] <= {root_in[k][ROOT_W-2:0], ge[k]};
				rad_s[k]  <= rad_in[k];
			end
		end
	end

	assign root = root_s[ROOT_W-1];

endmodule

>>> rtl/triangle_face_normal.sv
// Unit face normal of a triangle: cross product of (C - A) and (B - A),
// scaled to unit length, signed Q1.14 components.
// Uses tfn_pkg, tfn_cross, tfn_norm, tfn_div and tfn_isqrt.
//
// Input channel face_valid / face_stall / face carries one triangle per
// transaction, three vertices in signed Q8.8. Output channel normal_valid /
// normal_stall / normal carries the normal and a degenerate flag; a zero
// cross product gives a zero vector with the flag set.
// The pipeline has 56 register stages: 4 of edge and cross product, 4 of
// normalization and squares, 31 of division (one quotient bit per stage), 16 of
// square root (one root bit per stage) and 1 output register that also rounds
// and applies the sign. Throughput is one triangle per cycle while no finished
// normal is held by normal_stall.
// The whole pipeline advances together; while a finished normal is held by
// normal_stall, every stage holds and face_stall is raised, so nothing is
// dropped or repeated. Bubbles in flight are not squeezed out.
// Reset clears every valid bit; the pipeline is empty and ready after reset.
module triangle_face_normal import tfn_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    face_valid,
	output logic    face_stall,
	input  face_t   face,
	output logic    normal_valid,
	input  logic    normal_stall,
	output normal_t normal
);

	logic              adv;
	logic              cr_v, nm_v;
	logic [2:0]        cr_neg;
	logic [MAG_W-1:0]  cr_mag [3];
	tag_t              nm_tag;
	logic [SQ_W-1:0]   nm_sq [3];
	logic [SUM_W-1:0]  nm_sum;
	logic [QUO_W-1:0]  quo [3];
	logic [ROOT_W-1:0] root [3];
	logic              v_line_q   [LINE_DEPTH];
	tag_t              tag_line_q [LINE_DEPTH];
	logic              out_v_q;
	normal_t           out_q;
	logic [ROOT_W:0]   half [3];
	logic [OUT_BITS-1:0] mag_q [3];
	logic [OUT_BITS-1:0] comp [3];
	tag_t              last_tag;

	// advance everything unless a finished normal is held
	assign adv        = !(out_v_q && normal_stall);
	assign face_stall = !adv;

	tfn_cross u_cross (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.in_v   (face_valid),
		.face   (face),
		.out_v  (cr_v),
		.neg    (cr_neg),
		.mag    (cr_mag)
	);

	tfn_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.in_v   (cr_v),
		.neg    (cr_neg),
		.mag    (cr_mag),
		.out_v  (nm_v),
		.tag    (nm_tag),
		.sq     (nm_sq),
		.sum    (nm_sum)
	);

	for (genvar i = 0; i < 3; i++) begin : g_comp
		tfn_div u_div (
			.clk (clk),
			.adv (adv),
			.sq  (nm_sq[i]),
			.sum (nm_sum),
			.quo (quo[i])
		);

		tfn_isqrt u_isqrt (
			.clk  (clk),
			.adv  (adv),
			.rad  (quo[i]),
			.root (root[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LINE_DEPTH; k++) begin
				v_line_q[k] <= 1'b0;
			end
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_line_q[0] <= nm_v;
			for (int k = 1; k < LINE_DEPTH; k++) begin
				v_line_q[k] <= v_line_q[k-1];
			end
			out_v_q <= v_line_q[LINE_DEPTH-1];
		end
	end

	always_comb begin
		last_tag = tag_line_q[LINE_DEPTH-1];
		for (int i = 0; i < 3; i++) begin
			// round half up: q = (root + 1) / 2, capped at one
			half[i] = ((ROOT_W + 1)'(root[i]) + 1'b1) >> 1;
			mag_q[i] = (half[i] > (ROOT_W + 1)'(UNIT_Q)) ? OUT_BITS'(UNIT_Q)
				: OUT_BITS'(half[i]);
			if (last_tag.degen) begin
				comp[i] = '0;
			end else if (last_tag.neg[i]) begin
				comp[i] = ~mag_q[i] + 1'b1;
			end else begin
				comp[i] = mag_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_line_q[0] <= nm_tag;
			for (int k = 1; k < LINE_DEPTH; k++) begin
				tag_line_q[k] <= tag_line_q[k-1];
			end
			out_q.nx         <= comp[0];
			out_q.ny         <= comp[1];
			out_q.nz         <= comp[2];
			out_q.degenerate <= last_tag.degen;
		end
	end

	assign normal_valid = out_v_q;
	assign normal       = out_q;

endmodule

>>> rtl/tfn_check.sv
// Port-level checks for triangle_face_normal, attached by the bind below.
// Uses tfn_pkg.
module tfn_check import tfn_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    face_stall,
	input logic    normal_valid,
	input logic    normal_stall,
	input normal_t normal
);

	// a degenerate triangle yields the zero vector
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		normal_valid && normal.degenerate |->
			normal.nx == 0 && normal.ny == 0 && normal.nz == 0)
		else $error("degenerate normal not zero");

	// a proper triangle always has a nonzero largest component
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		normal_valid && !normal.degenerate |->
			normal.nx != 0 || normal.ny != 0 || normal.nz != 0)
		else $error("zero normal without degenerate flag");

	// input is held only by a held output transaction
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		face_stall |-> normal_valid && normal_stall)
		else $error("input stalled without output backpressure");

	// a held output transaction keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		normal_valid && normal_stall |=> normal_valid && $stable(normal))
		else $error("stalled output changed");

endmodule

bind triangle_face_normal tfn_check u_tfn_check (.*);
